[design/lz77d_pkg.sv]
// package for the lz77 token decompressor
// types, constants and command codes shared by the front, back and top level
// no dependencies
package lz77d_pkg;

	localparam int WindowBytesDefault = 65536;
	localparam int Lanes = 8;
	localparam int CmdDepth = 4;
	localparam int OutDepth = 2;

	localparam logic [8:0] MinMatch = 9'd3;
	localparam logic [16:0] MaxMatch = 17'd258;
	localparam logic [7:0] TagMatch = 8'h80;
	localparam logic [29:0] LimitReset = 30'd536870912;

	// status codes
	localparam logic [2:0] StRun = 3'd0;
	localparam logic [2:0] StOk = 3'd1;
	localparam logic [2:0] StTrunc = 3'd2;
	localparam logic [2:0] StDist = 3'd3;
	localparam logic [2:0] StLimit = 3'd4;
	localparam logic [2:0] StLong = 3'd5;

	typedef enum logic [1:0] {
		CMD_EMPTY,
		CMD_LIT,
		CMD_MATCH
	} cmd_kind_t;

	// one work command from front to back
	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] data;
		logic [8:0] len;
		logic [15:0] distance;
		logic [2:0] status;
		logic restart;
	} cmd_t;

	// one output chunk
	typedef struct packed {
		logic [Lanes-1:0][7:0] bytes;
		logic [3:0] count;
		logic run_last;
		logic [2:0] status;
	} result_t;

endpackage

[design/lz77d_ram.sv]
// generic simple dual port ram with registered read
// depends on nothing
module lz77d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/lz77d_fifo.sv]
// small register fifo used for the command queue and the result queue
// depends on nothing
module lz77d_fifo #(
	parameter type T = logic [7:0],
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input T wdata,
	input logic rd,
	output T rdata,
	output logic full,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	T slots_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slots_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/lz77d_front.sv]
// front parser: accepts compressed bytes, runs the checks, issues commands
// depends on lz77d_pkg
module lz77d_front import lz77d_pkg::*; #(
	parameter int WINDOW_BYTES = WindowBytesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic cfg_wr,
	input logic [29:0] cfg_data,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LIT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DIST_LO,
		PH_DIST_HI
	} phase_t;

	localparam logic [30:0] Window = 31'(WINDOW_BYTES);

	phase_t phase_q, phase_d;
	logic [6:0] lit_left_q, lit_left_d;
	logic [15:0] len_field_q, len_field_d;
	logic [7:0] dist_lo_q, dist_lo_d;
	logic [29:0] produced_q, produced_d;
	logic err_q, err_d;
	logic [2:0] err_code_q, err_code_d;
	logic [29:0] max_out_q;

	logic [16:0] match_len;
	logic [15:0] match_dist;
	logic [30:0] lit_sum;
	logic [30:0] match_sum;
	logic do_fail;
	logic [2:0] fail_code;
	logic restart;

	assign match_len = 17'(len_field_q) + 17'(MinMatch);
	assign match_dist = {in_byte, dist_lo_q};
	assign lit_sum = 31'(produced_q) + 31'(in_byte);
	assign match_sum = 31'(produced_q) + 31'(match_len);

	// parse one byte, classify it and build its command
	always_comb begin
		phase_d = phase_q;
		lit_left_d = lit_left_q;
		len_field_d = len_field_q;
		dist_lo_d = dist_lo_q;
		produced_d = produced_q;
		err_d = err_q;
		err_code_d = err_code_q;
		do_fail = 1'b0;
		fail_code = StRun;
		restart = in_last;
		cmd = '0;
		cmd.kind = CMD_EMPTY;
		cmd.status = in_last ? StOk : StRun;
		if (err_q) begin
			cmd.status = err_code_q;
		end else begin
			unique case (phase_q)
				PH_TAG: begin
					if (in_byte < TagMatch) begin
						if (in_byte == 8'd0) begin
							// empty run, nothing to do
						end else if (in_last) begin
							do_fail = 1'b1;
							fail_code = StTrunc;
						end else if (lit_sum > 31'(max_out_q)) begin
							do_fail = 1'b1;
							fail_code = StLimit;
						end else begin
							lit_left_d = in_byte[6:0];
							phase_d = PH_LIT;
						end
					end else if (in_last) begin
						do_fail = 1'b1;
						fail_code = StTrunc;
					end else begin
						phase_d = PH_LEN_LO;
					end
				end
				PH_LIT: begin
					if (in_last && lit_left_q > 7'd1) begin
						do_fail = 1'b1;
						fail_code = StTrunc;
					end else begin
						cmd.kind = CMD_LIT;
						cmd.data = in_byte;
						produced_d = produced_q + 30'd1;
						lit_left_d = lit_left_q - 7'd1;
						if (lit_left_q == 7'd1) begin
							phase_d = PH_TAG;
						end
					end
				end
				PH_LEN_LO: begin
					if (in_last) begin
						do_fail = 1'b1;
						fail_code = StTrunc;
					end else begin
						len_field_d = {8'd0, in_byte};
						phase_d = PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					if (in_last) begin
						do_fail = 1'b1;
						fail_code = StTrunc;
					end else begin
						len_field_d = {in_byte, len_field_q[7:0]};
						phase_d = PH_DIST_LO;
					end
				end
				PH_DIST_LO: begin
					if (in_last) begin
						do_fail = 1'b1;
						fail_code = StTrunc;
					end else begin
						dist_lo_d = in_byte;
						phase_d = PH_DIST_HI;
					end
				end
				PH_DIST_HI: begin
					if (match_dist == 16'd0 || 30'(match_dist) > produced_q ||
							31'(match_dist) > Window) begin
						do_fail = 1'b1;
						fail_code = StDist;
					end else if (match_sum > 31'(max_out_q)) begin
						do_fail = 1'b1;
						fail_code = StLimit;
					end else if (match_len > MaxMatch) begin
						do_fail = 1'b1;
						fail_code = StLong;
					end else begin
						cmd.kind = CMD_MATCH;
						cmd.len = match_len[8:0];
						cmd.distance = match_dist;
						produced_d = match_sum[29:0];
						phase_d = PH_TAG;
					end
				end
				default: begin
					phase_d = PH_TAG;
				end
			endcase
			if (do_fail) begin
				cmd.status = fail_code;
				if (!in_last) begin
					err_d = 1'b1;
					err_code_d = fail_code;
				end
			end
		end
		// stream end returns the parse state to its reset values
		if (in_last) begin
			phase_d = PH_TAG;
			lit_left_d = '0;
			len_field_d = '0;
			dist_lo_d = '0;
			produced_d = '0;
			err_d = 1'b0;
			err_code_d = StRun;
		end
		cmd.restart = restart;
	end

	// parse state and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			lit_left_q <= '0;
			len_field_q <= '0;
			dist_lo_q <= '0;
			produced_q <= '0;
			err_q <= 1'b0;
			err_code_q <= StRun;
			max_out_q <= LimitReset;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				lit_left_q <= lit_left_d;
				len_field_q <= len_field_d;
				dist_lo_q <= dist_lo_d;
				produced_q <= produced_d;
				err_q <= err_d;
				err_code_q <= err_code_d;
			end
			if (cfg_wr) begin
				max_out_q <= cfg_data;
			end
		end
	end

endmodule

[design/lz77d_back.sv]
// back executor: writes literals to history and expands matches into chunks
// depends on lz77d_pkg and lz77d_ram
module lz77d_back import lz77d_pkg::*; #(
	parameter int WINDOW_BYTES = WindowBytesDefault
) (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	input logic cmd_empty,
	output logic cmd_pop,
	input logic res_full,
	output logic res_push,
	output result_t res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_EMIT
	} state_t;

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam logic [16:0] Window = 17'(WINDOW_BYTES);

	state_t state_q;
	logic [AW-1:0] ptr_q;
	logic [8:0] len_q;
	logic [8:0] done_q;
	logic [15:0] dist_q;
	logic [2:0] status_q;
	logic restart_q;
	logic [3:0] fill_q;
	logic [Lanes-1:0][7:0] chunk_q;

	logic we;
	logic [7:0] wdata;
	logic [AW-1:0] raddr;
	logic [7:0] rdata;
	logic [16:0] ptr_ext;
	logic [16:0] src_ext;
	logic [AW-1:0] ptr_inc;

	lz77d_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_hist (
		.clk(clk),
		.we(we),
		.waddr(ptr_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// source address wraps around the window
	assign ptr_ext = 17'(ptr_q);
	assign src_ext = (ptr_ext >= 17'(dist_q)) ? ptr_ext - 17'(dist_q)
		: ptr_ext + Window - 17'(dist_q);
	assign raddr = src_ext[AW-1:0];
	assign ptr_inc = (ptr_q == AW'(WINDOW_BYTES - 1)) ? '0 : ptr_q + 1'b1;

	// history write, command pop and result transfer
	always_comb begin
		we = 1'b0;
		wdata = cmd.data;
		cmd_pop = 1'b0;
		res_push = 1'b0;
		res = '0;
		res.run_last = 1'b1;
		res.status = cmd.status;
		unique case (state_q)
			S_IDLE: begin
				if (!cmd_empty) begin
					if (cmd.kind == CMD_MATCH) begin
						cmd_pop = 1'b1;
					end else if (!res_full) begin
						cmd_pop = 1'b1;
						res_push = 1'b1;
						if (cmd.kind == CMD_LIT) begin
							we = 1'b1;
							res.bytes[0] = cmd.data;
							res.count = 4'd1;
						end
					end
				end
			end
			S_WR: begin
				we = 1'b1;
				wdata = rdata;
			end
			S_EMIT: begin
				res.bytes = chunk_q;
				res.count = fill_q;
				res.run_last = (done_q == len_q);
				res.status = status_q;
				res_push = !res_full;
			end
			default: begin
			end
		endcase
	end

	// copy sequencer: read a byte, write it back, gather chunks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q <= '0;
			len_q <= '0;
			done_q <= '0;
			dist_q <= '0;
			status_q <= StRun;
			restart_q <= 1'b0;
			fill_q <= '0;
			chunk_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						if (cmd.kind == CMD_MATCH) begin
							len_q <= cmd.len;
							dist_q <= cmd.distance;
							status_q <= cmd.status;
							restart_q <= cmd.restart;
							done_q <= '0;
							fill_q <= '0;
							chunk_q <= '0;
							state_q <= S_RD;
						end else if (!res_full) begin
							if (cmd.restart) begin
								ptr_q <= '0;
							end else if (cmd.kind == CMD_LIT) begin
								ptr_q <= ptr_inc;
							end
						end
					end
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					ptr_q <= ptr_inc;
					chunk_q[fill_q[2:0]] <= rdata;
					fill_q <= fill_q + 4'd1;
					done_q <= done_q + 9'd1;
					if (fill_q == 4'(Lanes - 1) || done_q + 9'd1 == len_q) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					if (!res_full) begin
						fill_q <= '0;
						chunk_q <= '0;
						if (done_q == len_q) begin
							if (restart_q) begin
								ptr_q <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[design/lz77_token_decompressor.sv]
// top level of the lz77 token decompressor
// depends on lz77d_pkg, lz77d_front, lz77d_back, lz77d_fifo and lz77d_ram
//
// Compressed bytes enter one per cycle while full is low, through a queue-style
// push/full port, and decompressed chunks of up to eight bytes leave through an
// empty/pop port. The front parser takes a byte whenever its command queue has
// room; the back unit handles tag, token and literal commands directly in its
// idle state. A match is copied byte by byte: each byte is read from and then
// written back to the history memory (one read port, registered read), and
// each chunk goes to the result queue. The limit register max_out_q is written
// through cfg_valid/cfg_data and is always ready; write it only while idle.
module lz77_token_decompressor import lz77d_pkg::*; #(
	parameter int WINDOW_BYTES = WindowBytesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] in_byte,
	input logic in_last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [29:0] cfg_data,
	output logic empty,
	input logic pop,
	output logic [7:0] byte_0,
	output logic [7:0] byte_1,
	output logic [7:0] byte_2,
	output logic [7:0] byte_3,
	output logic [7:0] byte_4,
	output logic [7:0] byte_5,
	output logic [7:0] byte_6,
	output logic [7:0] byte_7,
	output logic [3:0] byte_count,
	output logic run_last,
	output logic [2:0] status
);

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_pop;
	logic accept;
	result_t res_in;
	result_t res_out;
	logic res_push;
	logic res_full;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign cfg_ready = 1'b1;

	lz77d_front #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.in_byte(in_byte),
		.in_last(in_last),
		.cfg_wr(cfg_valid),
		.cfg_data(cfg_data),
		.cmd(cmd_in)
	);

	// command queue between parser and executor
	lz77d_fifo #(
		.T(cmd_t),
		.DEPTH(CmdDepth)
	) u_cmd_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr(accept),
		.wdata(cmd_in),
		.rd(cmd_pop),
		.rdata(cmd_out),
		.full(cmd_full),
		.empty(cmd_empty)
	);

	lz77d_back #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in)
	);

	// result queue toward the consumer
	lz77d_fifo #(
		.T(result_t),
		.DEPTH(OutDepth)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.wr(res_push),
		.wdata(res_in),
		.rd(pop),
		.rdata(res_out),
		.full(res_full),
		.empty(empty)
	);

	assign byte_0 = res_out.bytes[0];
	assign byte_1 = res_out.bytes[1];
	assign byte_2 = res_out.bytes[2];
	assign byte_3 = res_out.bytes[3];
	assign byte_4 = res_out.bytes[4];
	assign byte_5 = res_out.bytes[5];
	assign byte_6 = res_out.bytes[6];
	assign byte_7 = res_out.bytes[7];
	assign byte_count = res_out.count;
	assign run_last = res_out.run_last;
	assign status = res_out.status;

endmodule
